>>> rtl/lwes_pkg.sv
// shared constants, types and the arctangent table for the wave elevation synthesizer
// no dependencies
package lwes_pkg;

  localparam int MAX_COMPONENTS = 64;
  localparam int CORDIC_ITERS   = 24;

  localparam int IDX_W  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int CNT_W  = $clog2(MAX_COMPONENTS + 1);
  localparam int ITER_W = (CORDIC_ITERS > 1) ? $clog2(CORDIC_ITERS) : 1;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 18;
  localparam int ACT_W     = 7;
  localparam int OUT_W     = 40;
  localparam int ACC_W     = 48;

  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic [18:0] TWO_PI_Q16 = 19'd411775;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIR_COS = 2'd0,
    CFG_DIR_SIN = 2'd1,
    CFG_ACTIVE  = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_EVAL = 1'b1
  } mode_t;

  typedef struct packed {
    logic              cap;
    logic              wr;
    logic              xsum;
    logic              p1;
    logic              p2;
    logic              cinit;
    logic              citer;
    logic              rot;
    logic              mul;
    logic              acc;
    logic              oload;
    logic [ITER_W-1:0] iter;
    logic [IDX_W-1:0]  addr;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] n_act;
  } status_t;

  function automatic logic [31:0] atan_at(input logic [ITER_W-1:0] i);
    return ATAN_TURNS[i];
  endfunction

endpackage

>>> rtl/lwes_in_if.sv
// input channel: load or evaluate word
// no dependencies
interface lwes_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [5:0]  comp_index;
  logic [31:0] amplitude;
  logic [31:0] wave_number;
  logic [31:0] frequency;
  logic [23:0] phase_offset;
  logic [31:0] x_pos;
  logic [31:0] y_pos;
  logic [31:0] sim_time;

  modport source (output valid, mode, comp_index, amplitude, wave_number, frequency,
                  phase_offset, x_pos, y_pos, sim_time, input ready);
  modport sink   (input valid, mode, comp_index, amplitude, wave_number, frequency,
                  phase_offset, x_pos, y_pos, sim_time, output ready);
endinterface

>>> rtl/lwes_out_if.sv
// result channel: elevation, rate and clip flag
// depends on lwes_pkg
interface lwes_out_if;
  import lwes_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] elevation;
  logic [OUT_W-1:0] elevation_rate;
  logic             saturated;

  modport source (output valid, elevation, elevation_rate, saturated, input ready);
  modport sink   (input valid, elevation, elevation_rate, saturated, output ready);
endinterface

>>> rtl/lwes_cfg_if.sv
// configuration write channel
// depends on lwes_pkg
interface lwes_cfg_if;
  import lwes_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/lwes_dp.sv
// datapath: config registers, component table, phase arithmetic, cordic, accumulators
// depends on lwes_pkg
module lwes_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lwes_pkg::cmd_t           cmd,
  output lwes_pkg::status_t        status,
  input  logic                     cfg_valid,
  input  logic [1:0]               cfg_index,
  input  logic [17:0]              cfg_data,
  input  logic [5:0]               in_comp_index,
  input  logic [31:0]              in_amplitude,
  input  logic [31:0]              in_wave_number,
  input  logic [31:0]              in_frequency,
  input  logic [23:0]              in_phase_offset,
  input  logic [31:0]              in_x_pos,
  input  logic [31:0]              in_y_pos,
  input  logic [31:0]              in_sim_time,
  output logic [39:0]              out_elevation,
  output logic [39:0]              out_elevation_rate,
  output logic                     out_saturated
);
  import lwes_pkg::*;

  logic signed [17:0] cos_r, sin_r;
  logic [ACT_W-1:0]   active_r;

  logic [119:0] mem [MAX_COMPONENTS];
  logic [119:0] q_r;
  logic [31:0]  amp, kwn, frq;
  logic [23:0]  phi;

  logic signed [31:0] x_r, y_r;
  logic [31:0]        t_r;
  logic signed [49:0] px, py;
  logic signed [50:0] xx_r;

  logic [63:0] m0_r, ft_r, fat_r;
  logic [27:0] m1_r, xh28;
  logic [63:0] kx;
  logic [31:0] theta_r;
  logic [35:0] fa;
  logic [50:0] walo_r;
  logic [22:0] wahi_r;
  logic [54:0] wsum;
  logic [38:0] wa_r;

  logic [31:0] qsum, zres;
  logic [1:0]  quad_r;
  logic signed [33:0] cx_r, cy_r, xs, ys, co_r, si_r;
  logic signed [32:0] z_r, at;

  logic signed [66:0] elp_r;
  logic signed [25:0] s8;
  logic signed [58:0] rlo_r;
  logic signed [33:0] rhi_r;
  logic signed [65:0] rp;
  logic signed [ACC_W-1:0] el_r, rt_r;
  logic el_sat, rt_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r    <= 18'sd65536;
      sin_r    <= '0;
      active_r <= ACT_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DIR_COS: cos_r    <= $signed(cfg_data);
        CFG_DIR_SIN: sin_r    <= $signed(cfg_data);
        CFG_ACTIVE:  active_r <= cfg_data[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(active_r) >= MAX_COMPONENTS) status.n_act = CNT_W'(MAX_COMPONENTS);
    else status.n_act = CNT_W'(active_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && (int'(in_comp_index) < MAX_COMPONENTS))
      mem[IDX_W'(in_comp_index)] <= {in_amplitude, in_wave_number, in_frequency,
                                     in_phase_offset};
    q_r <= mem[cmd.addr];
  end

  assign {amp, kwn, frq, phi} = q_r;

  assign px   = x_r * cos_r;
  assign py   = y_r * sin_r;
  assign xh28 = {{9{xx_r[50]}}, xx_r[50:32]};
  assign kx   = m0_r + {4'b0, m1_r, 32'b0};
  assign fa   = fat_r[63:28];
  assign wsum = 55'(walo_r) + {wahi_r, 32'b0};
  assign qsum = theta_r + 32'h2000_0000;
  assign zres = theta_r - {qsum[31:30], 30'b0};
  assign xs   = cx_r >>> cmd.iter;
  assign ys   = cy_r >>> cmd.iter;
  assign at   = $signed({1'b0, atan_at(cmd.iter)});
  assign s8   = si_r[33:8];
  assign rp   = {{7{rlo_r[58]}}, rlo_r} + {rhi_r, 32'b0};

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      x_r <= $signed(in_x_pos);
      y_r <= $signed(in_y_pos);
      t_r <= in_sim_time;
    end
    if (cmd.xsum) xx_r <= {px[49], px} + {py[49], py};
    if (cmd.p1) begin
      m0_r  <= 64'(kwn) * 64'(xx_r[31:0]);
      m1_r  <= kwn[27:0] * xh28;
      ft_r  <= 64'(frq) * 64'(t_r);
      fat_r <= 64'(frq) * 64'(amp);
    end
    if (cmd.p2) begin
      theta_r <= kx[59:28] - ft_r[43:12] + {phi, 8'b0};
      walo_r  <= 51'(fa[31:0]) * 51'(TWO_PI_Q16);
      wahi_r  <= 23'(fa[35:32]) * 23'(TWO_PI_Q16);
    end
    if (cmd.cinit) begin
      quad_r <= qsum[31:30];
      z_r    <= $signed({zres[31], zres});
      cx_r   <= CORDIC_START;
      cy_r   <= '0;
      wa_r   <= wsum[54:16];
    end
    if (cmd.citer) begin
      if (!z_r[32]) begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        z_r  <= z_r - at;
      end else begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        z_r  <= z_r + at;
      end
    end
    if (cmd.rot) begin
      case (quad_r)
        2'd0: begin co_r <= cx_r;  si_r <= cy_r;  end
        2'd1: begin co_r <= -cy_r; si_r <= cx_r;  end
        2'd2: begin co_r <= -cx_r; si_r <= -cy_r; end
        default: begin co_r <= cy_r; si_r <= -cx_r; end
      endcase
    end
    if (cmd.mul) begin
      elp_r <= $signed({1'b0, amp}) * co_r;
      rlo_r <= $signed({1'b0, wa_r[31:0]}) * s8;
      rhi_r <= $signed({1'b0, wa_r[38:32]}) * s8;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      el_r <= '0;
      rt_r <= '0;
    end else if (cmd.acc) begin
      el_r <= el_r + {{11{elp_r[66]}}, elp_r[66:30]};
      rt_r <= rt_r + {{4{rp[65]}}, rp[65:22]};
    end
  end

  assign el_sat = !((&el_r[47:39]) || !(|el_r[47:39]));
  assign rt_sat = !((&rt_r[47:39]) || !(|rt_r[47:39]));

  always_ff @(posedge clk) begin
    if (cmd.oload) begin
      out_elevation      <= el_sat ? {el_r[47], {39{!el_r[47]}}} : el_r[39:0];
      out_elevation_rate <= rt_sat ? {rt_r[47], {39{!rt_r[47]}}} : rt_r[39:0];
      out_saturated      <= el_sat | rt_sat;
    end
  end

endmodule

>>> rtl/lwes_ctrl.sv
// controller: sequences components through the datapath and owns the handshakes
// depends on lwes_pkg
module lwes_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_mode,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  lwes_pkg::status_t   status,
  output lwes_pkg::cmd_t      cmd
);
  import lwes_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_XMUL, S_XSUM, S_RD, S_P1, S_P2, S_CINIT, S_CORD, S_ROT, S_MUL, S_ACC, S_FIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  comp_r, comp_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              acc_in, fin_go;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign acc_in    = in_valid && in_ready;
  assign fin_go    = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    comp_nxt      = comp_r;
    iter_nxt      = iter_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (acc_in && mode_t'(in_mode) == MODE_EVAL) state_nxt = S_XMUL;
      end
      S_XMUL: state_nxt = S_XSUM;
      S_XSUM: begin
        comp_nxt  = '0;
        state_nxt = (status.n_act == '0) ? S_FIN : S_RD;
      end
      S_RD:    state_nxt = S_P1;
      S_P1:    state_nxt = S_P2;
      S_P2:    state_nxt = S_CINIT;
      S_CINIT: begin
        iter_nxt  = '0;
        state_nxt = S_CORD;
      end
      S_CORD: begin
        iter_nxt = iter_r + ITER_W'(1);
        if (int'(iter_r) == CORDIC_ITERS - 1) state_nxt = S_ROT;
      end
      S_ROT: state_nxt = S_MUL;
      S_MUL: state_nxt = S_ACC;
      S_ACC: begin
        comp_nxt  = comp_r + CNT_W'(1);
        state_nxt = (comp_r + CNT_W'(1) == status.n_act) ? S_FIN : S_RD;
      end
      S_FIN: begin
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.cap   = acc_in && mode_t'(in_mode) == MODE_EVAL;
    cmd.wr    = acc_in && mode_t'(in_mode) == MODE_LOAD;
    cmd.xsum  = (state_r == S_XSUM);
    cmd.p1    = (state_r == S_P1);
    cmd.p2    = (state_r == S_P2);
    cmd.cinit = (state_r == S_CINIT);
    cmd.citer = (state_r == S_CORD);
    cmd.rot   = (state_r == S_ROT);
    cmd.mul   = (state_r == S_MUL);
    cmd.acc   = (state_r == S_ACC);
    cmd.oload = fin_go;
    cmd.iter  = iter_r;
    cmd.addr  = comp_r[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      comp_r      <= '0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      comp_r      <= comp_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/linear_wave_elevation_synth.sv
// top level: sum-of-sinusoids wave elevation and rate, one evaluation at a time
// a load word is written to the table when taken; an evaluation runs the n active
// components in turn through the shared cordic, which iterates once per cycle; the
// next word is taken once the result is registered
// synchronous active-low reset clears control and config; the component table is
// not cleared and needs writing before use
module linear_wave_elevation_synth (
  input  logic       clk,
  input  logic       rst_n,
  lwes_in_if.sink    in_if,
  lwes_out_if.source out_if,
  lwes_cfg_if.sink   cfg_if
);
  import lwes_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_if.ready = 1'b1;

  lwes_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_mode   (in_if.mode),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lwes_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_valid          (cfg_if.valid),
    .cfg_index          (cfg_if.index),
    .cfg_data           (cfg_if.data),
    .in_comp_index      (in_if.comp_index),
    .in_amplitude       (in_if.amplitude),
    .in_wave_number     (in_if.wave_number),
    .in_frequency       (in_if.frequency),
    .in_phase_offset    (in_if.phase_offset),
    .in_x_pos           (in_if.x_pos),
    .in_y_pos           (in_if.y_pos),
    .in_sim_time        (in_if.sim_time),
    .out_elevation      (out_if.elevation),
    .out_elevation_rate (out_if.elevation_rate),
    .out_saturated      (out_if.saturated)
  );

endmodule

>>> rtl/lwes_chk.sv
// port-level checks for the wave elevation synthesizer, bound to the top level
// depends on lwes_pkg
module lwes_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_mode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [39:0] out_elevation,
  input logic [39:0] out_elevation_rate,
  input logic        out_saturated
);
  import lwes_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_elevation) &&
    $stable(out_elevation_rate))
    else $error("result dropped or changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_EVAL |=> !in_ready)
    else $error("word taken during evaluation");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_elevation == 40'h7F_FFFF_FFFF || out_elevation == 40'h80_0000_0000 ||
      out_elevation_rate == 40'h7F_FFFF_FFFF || out_elevation_rate == 40'h80_0000_0000)
    else $error("clip flag without a clipped sum");

endmodule

bind linear_wave_elevation_synth lwes_chk u_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_if.valid),
  .in_ready           (in_if.ready),
  .in_mode            (in_if.mode),
  .out_valid          (out_if.valid),
  .out_ready          (out_if.ready),
  .out_elevation      (out_if.elevation),
  .out_elevation_rate (out_if.elevation_rate),
  .out_saturated      (out_if.saturated)
);
